@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define MCR_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define MCR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mcr_pkg.sv @@
// Shared types and constants of the midpoint circle rasterizer.
package mcr_pkg;

    localparam int MaxRadius = 1023;
    localparam int RadiusW   = 10;
    localparam int CoordW    = 11;
    localparam int PosW      = 12;
    localparam int StepW     = 12;
    // Wide enough for the decision value even if the radius shrinks mid-circle.
    localparam int ErrW      = 22;
    localparam int BeatW     = 3;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 10;

    localparam logic [CfgIdxW-1:0] REG_RADIUS    = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_FILL_MODE = 2'd1;

    localparam logic [BeatW-1:0] LAST_BEAT_DONE    = 3'd0;
    localparam logic [BeatW-1:0] LAST_BEAT_FILL    = 3'd3;
    localparam logic [BeatW-1:0] LAST_BEAT_OUTLINE = 3'd7;

    // One step's worth of output: the pixel and fill flags and the four canvas offsets of the octant point.
    typedef struct packed {
        logic              pix;
        logic              fill;
        logic [CoordW-1:0] r_plus_x;
        logic [CoordW-1:0] r_minus_x;
        logic [CoordW-1:0] r_plus_y;
        logic [CoordW-1:0] r_minus_y;
    } step_rec_t;

endpackage

@@ rtl/mcr_step.sv @@
// Step unit: circle state registers, one midpoint step per accepted beat while a circle is active, else a done record.
module mcr_step (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_start_req,
    input  logic [mcr_pkg::RadiusW-1:0]     radius,
    input  logic                            fill_mode,
    input  logic                            emit_load,
    output logic                            hold_valid,
    output mcr_pkg::step_rec_t              hold_rec
);

    logic signed [mcr_pkg::PosW-1:0]  x_reg, x_next, x_ld, x_upd;
    logic signed [mcr_pkg::PosW-1:0]  y_reg, y_next, y_ld, y_upd;
    logic        [mcr_pkg::StepW-1:0] dx_reg, dx_next, dx_ld, dx_upd;
    logic        [mcr_pkg::StepW-1:0] dy_reg, dy_next, dy_ld, dy_upd;
    logic signed [mcr_pkg::ErrW-1:0]  err_reg, err_next, err_ld, err_mid, err_upd;
    logic                             active_reg, active_next, active_ld;
    logic                             hold_valid_reg;
    mcr_pkg::step_rec_t               hold_rec_reg, rec_next;
    logic [mcr_pkg::RadiusW-1:0]      r_eff;
    logic [mcr_pkg::CoordW-1:0]       r_c;
    logic [mcr_pkg::ErrW-1:0]         two_r;
    logic                             emit, accept;

    assign s_ready    = ~hold_valid_reg | emit_load;
    assign accept     = s_valid & s_ready;
    assign hold_valid = hold_valid_reg;
    assign hold_rec   = hold_rec_reg;

    always_comb begin
        r_eff = (radius > mcr_pkg::RadiusW'(mcr_pkg::MaxRadius)) ?
                mcr_pkg::RadiusW'(mcr_pkg::MaxRadius) : radius;
        r_c   = mcr_pkg::CoordW'(r_eff);
        two_r = mcr_pkg::ErrW'({r_eff, 1'b0});

        // A start request reloads the state before the step is taken.
        if (s_start_req) begin
            x_ld      = mcr_pkg::PosW'(r_eff) - mcr_pkg::PosW'(1);
            y_ld      = '0;
            dx_ld     = mcr_pkg::StepW'(1);
            dy_ld     = mcr_pkg::StepW'(1);
            err_ld    = mcr_pkg::ErrW'(1) - two_r;
            active_ld = 1'b1;
        end else begin
            x_ld      = x_reg;
            y_ld      = y_reg;
            dx_ld     = dx_reg;
            dy_ld     = dy_reg;
            err_ld    = err_reg;
            active_ld = active_reg;
        end

        emit = active_ld & (x_ld >= y_ld);

        if (err_ld[mcr_pkg::ErrW-1] | (err_ld == '0)) begin
            y_upd   = y_ld + mcr_pkg::PosW'(1);
            err_mid = err_ld + mcr_pkg::ErrW'(dy_ld);
            dy_upd  = dy_ld + mcr_pkg::StepW'(2);
        end else begin
            y_upd   = y_ld;
            err_mid = err_ld;
            dy_upd  = dy_ld;
        end

        if (~err_mid[mcr_pkg::ErrW-1] & (err_mid != '0)) begin
            x_upd   = x_ld - mcr_pkg::PosW'(1);
            dx_upd  = dx_ld + mcr_pkg::StepW'(2);
            err_upd = err_mid + mcr_pkg::ErrW'(dx_upd) - two_r;
        end else begin
            x_upd   = x_ld;
            dx_upd  = dx_ld;
            err_upd = err_mid;
        end

        if (emit) begin
            x_next      = x_upd;
            y_next      = y_upd;
            dx_next     = dx_upd;
            dy_next     = dy_upd;
            err_next    = err_upd;
            active_next = ~(x_upd < y_upd);
        end else begin
            x_next      = x_ld;
            y_next      = y_ld;
            dx_next     = dx_ld;
            dy_next     = dy_ld;
            err_next    = err_ld;
            active_next = 1'b0;
        end

        rec_next.pix  = emit;
        rec_next.fill = fill_mode;
        if (emit) begin
            rec_next.r_plus_x  = r_c + x_ld[mcr_pkg::CoordW-1:0];
            rec_next.r_minus_x = r_c - x_ld[mcr_pkg::CoordW-1:0];
            rec_next.r_plus_y  = r_c + y_ld[mcr_pkg::CoordW-1:0];
            rec_next.r_minus_y = r_c - y_ld[mcr_pkg::CoordW-1:0];
        end else begin
            rec_next.r_plus_x  = '0;
            rec_next.r_minus_x = '0;
            rec_next.r_plus_y  = '0;
            rec_next.r_minus_y = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg          <= '0;
            y_reg          <= '0;
            dx_reg         <= '0;
            dy_reg         <= '0;
            err_reg        <= '0;
            active_reg     <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else if (accept) begin
            x_reg          <= x_next;
            y_reg          <= y_next;
            dx_reg         <= dx_next;
            dy_reg         <= dy_next;
            err_reg        <= err_next;
            active_reg     <= active_next;
            hold_valid_reg <= 1'b1;
        end else if (emit_load) begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_rec_reg <= rec_next;
        end
    end

endmodule

@@ rtl/mcr_emit.sv @@
// Result serializer: sends the points or spans of one step, or its done result, beat by beat.
module mcr_emit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        hold_valid,
    input  mcr_pkg::step_rec_t          hold_rec,
    output logic                        emit_load,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mcr_pkg::CoordW-1:0]  m_span_x_begin,
    output logic [mcr_pkg::CoordW-1:0]  m_span_x_end,
    output logic [mcr_pkg::CoordW-1:0]  m_span_row,
    output logic                        m_pixel_valid,
    output logic                        m_last,
    output logic                        m_done_res
);

    mcr_pkg::step_rec_t              rec_reg;
    logic                            busy_reg;
    logic [mcr_pkg::BeatW-1:0]       beat_reg;
    logic [mcr_pkg::BeatW-1:0]       last_beat_idx;
    logic                            last_beat, emit_free;
    logic [mcr_pkg::CoordW-1:0]      col_b, col_e, row;
    logic [mcr_pkg::CoordW-1:0]      a, b, c, d;

    assign a = rec_reg.r_plus_x;
    assign b = rec_reg.r_minus_x;
    assign c = rec_reg.r_plus_y;
    assign d = rec_reg.r_minus_y;

    always_comb begin
        priority if (!rec_reg.pix) begin
            last_beat_idx = mcr_pkg::LAST_BEAT_DONE;
        end else if (rec_reg.fill) begin
            last_beat_idx = mcr_pkg::LAST_BEAT_FILL;
        end else begin
            last_beat_idx = mcr_pkg::LAST_BEAT_OUTLINE;
        end
    end

    assign last_beat = (beat_reg == last_beat_idx);
    assign emit_free = ~busy_reg | (m_ready & last_beat);
    assign emit_load = hold_valid & emit_free;

    // Octant order for points, and the four span rows for the filled form.
    always_comb begin
        col_b = '0;
        col_e = '0;
        row   = '0;
        if (rec_reg.pix && rec_reg.fill) begin
            unique case (beat_reg[1:0])
                2'd0: begin col_b = d; col_e = c; row = b; end
                2'd1: begin col_b = b; col_e = a; row = d; end
                2'd2: begin col_b = b; col_e = a; row = c; end
                default: begin col_b = d; col_e = c; row = a; end
            endcase
        end else if (rec_reg.pix) begin
            unique case (beat_reg)
                3'd0: begin col_b = a; row = c; end
                3'd1: begin col_b = c; row = a; end
                3'd2: begin col_b = d; row = a; end
                3'd3: begin col_b = b; row = c; end
                3'd4: begin col_b = b; row = d; end
                3'd5: begin col_b = d; row = b; end
                3'd6: begin col_b = c; row = b; end
                default: begin col_b = a; row = d; end
            endcase
            col_e = col_b;
        end
    end

    assign m_valid        = busy_reg;
    assign m_span_x_begin = col_b;
    assign m_span_x_end   = col_e;
    assign m_span_row     = row;
    assign m_pixel_valid  = rec_reg.pix;
    assign m_last         = last_beat;
    assign m_done_res     = ~rec_reg.pix;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            beat_reg <= '0;
        end else if (emit_load) begin
            busy_reg <= 1'b1;
            beat_reg <= '0;
        end else if (busy_reg && m_ready) begin
            if (last_beat) begin
                busy_reg <= 1'b0;
            end else begin
                beat_reg <= beat_reg + mcr_pkg::BeatW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_load) begin
            rec_reg <= hold_rec;
        end
    end

endmodule

@@ rtl/midpoint_circle_rasterizer_top.sv @@
// A step's result is registered in the step unit's holding register, then in the serializer.
// A step is sent as 8 beats in outline mode, 4 in filled mode, 1 for a done result; the
// result port moves one beat per cycle while m_ready is high, and a one-step holding
// register lets the next input beat be accepted while the current step is still being sent.
// Reset is synchronous, active low; it clears the circle state, config registers and all valids.
// Top level of the midpoint circle rasterizer.
module midpoint_circle_rasterizer_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mcr_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [mcr_pkg::CfgDataW-1:0]  cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_start_req,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mcr_pkg::CoordW-1:0]    m_span_x_begin,
    output logic [mcr_pkg::CoordW-1:0]    m_span_x_end,
    output logic [mcr_pkg::CoordW-1:0]    m_span_row,
    output logic                          m_pixel_valid,
    output logic                          m_last,
    output logic                          m_done_res
);

    logic [mcr_pkg::RadiusW-1:0] radius_reg;
    logic                        fill_mode_reg;
    logic                        emit_load, hold_valid;
    mcr_pkg::step_rec_t          hold_rec;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg    <= '0;
            fill_mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_index == mcr_pkg::REG_RADIUS) begin
                radius_reg <= cfg_data[mcr_pkg::RadiusW-1:0];
            end
            if (cfg_index == mcr_pkg::REG_FILL_MODE) begin
                fill_mode_reg <= cfg_data[0];
            end
        end
    end

    mcr_step u_step (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_start_req (s_start_req),
        .radius      (radius_reg),
        .fill_mode   (fill_mode_reg),
        .emit_load   (emit_load),
        .hold_valid  (hold_valid),
        .hold_rec    (hold_rec)
    );

    mcr_emit u_emit (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .hold_valid     (hold_valid),
        .hold_rec       (hold_rec),
        .emit_load      (emit_load),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_span_x_begin (m_span_x_begin),
        .m_span_x_end   (m_span_x_end),
        .m_span_row     (m_span_row),
        .m_pixel_valid  (m_pixel_valid),
        .m_last         (m_last),
        .m_done_res     (m_done_res)
    );

endmodule

@@ rtl/mcr_checker.sv @@
// Port-level checker for the rasterizer, bound to the top level.
`include "assert_macros.svh"

module mcr_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [mcr_pkg::CoordW-1:0]    m_span_x_begin,
    input  logic [mcr_pkg::CoordW-1:0]    m_span_x_end,
    input  logic [mcr_pkg::CoordW-1:0]    m_span_row,
    input  logic                          m_pixel_valid,
    input  logic                          m_last,
    input  logic                          m_done_res
);

    // A done beat carries no coordinates and always closes its step.
    `MCR_ASSERT_IMPL(a_done_beat, aclk, aresetn, m_valid && m_done_res, m_last && !m_pixel_valid && m_span_x_begin == '0 && m_span_x_end == '0 && m_span_row == '0, "done beat malformed")

    // The rest of a step's points follow without a gap and without a done beat.
    `MCR_ASSERT_NEXT(a_step_burst, aclk, aresetn, m_valid && m_ready && !m_last, m_valid && m_pixel_valid, "gap inside a step")

    `MCR_ASSERT_NEXT(a_valid_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "result valid dropped")

    `MCR_ASSERT_NEXT(a_data_hold, aclk, aresetn, m_valid && !m_ready, $stable(m_span_x_begin) && $stable(m_span_x_end) && $stable(m_span_row) && $stable(m_last), "stalled result changed")

endmodule

bind midpoint_circle_rasterizer_top mcr_checker u_mcr_checker (.*);
